[design/fgrc_pkg.sv]
// Package: payload types, phase encoding and widths for the reach counter.
`timescale 1ns / 1ps
package fgrc_pkg;
	localparam int IDX_W = 6;
	localparam int CNT_W = 7;

	typedef struct packed {
		logic [IDX_W-1:0] successor;
		logic             last_node;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0] visited_count;
		logic             bad_graph;
		logic             end_of_run;
	} result_t;

	typedef enum logic [10:0] {
		PH_LOAD   = 11'b00000000001,
		PH_RANGE  = 11'b00000000010,
		PH_DEG    = 11'b00000000100,
		PH_SEED   = 11'b00000001000,
		PH_PEEL   = 11'b00000010000,
		PH_CSCAN  = 11'b00000100000,
		PH_CWALK  = 11'b00001000000,
		PH_CMARK  = 11'b00010000000,
		PH_TAIL   = 11'b00100000000,
		PH_EMIT   = 11'b01000000000,
		PH_CLEAR  = 11'b10000000000
	} phase_t;
endpackage

[design/fgrc_core.sv]
// Core: tables and a sequencer that walks them one access per cycle.
`timescale 1ns / 1ps
module fgrc_core #(
	parameter int MAX_NODES = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  fgrc_pkg::item_t        item,
	output logic                   busy,
	output logic                   strobe,
	output fgrc_pkg::result_t      result
);
	localparam int AW = fgrc_pkg::IDX_W;
	localparam int CW = fgrc_pkg::CNT_W;

	logic [AW-1:0] succ_mem [MAX_NODES];
	logic [CW-1:0] deg_mem  [MAX_NODES];
	logic [CW-1:0] ans_mem  [MAX_NODES];
	logic [AW-1:0] queue_mem[MAX_NODES];

	fgrc_pkg::phase_t ph_q;
	logic [CW-1:0] n_q;        // loaded nodes
	logic          err_q;
	logic [CW-1:0] v_q;        // scan index
	logic [CW-1:0] head_q, tail_q;
	logic [AW-1:0] w_q;        // walk pointer
	logic [CW-1:0] len_q;
	logic [1:0]    step_q;     // step within one table operation

	// registered read data, valid in the cycle after the address
	logic [AW-1:0] succ_rd_q;
	logic [CW-1:0] deg_rd_q;
	logic [CW-1:0] ans_rd_q;
	logic [AW-1:0] queue_rd_q;

	logic [AW-1:0] s_ra, d_ra, a_ra, q_ra;
	logic [AW-1:0] d_wa, a_wa, q_wa, q_wd;
	logic [CW-1:0] d_wd, a_wd;
	logic          d_we, a_we, q_we, ld_we;
	logic [CW-1:0] tail_dec;

	logic [AW-1:0] v_idx;
	logic          v_end;
	assign v_idx = v_q[AW-1:0];
	assign v_end = (v_q + CW'(1)) == n_q;
	assign tail_dec = tail_q - CW'(1);

	assign busy = (ph_q != fgrc_pkg::PH_LOAD);
	assign ld_we = (ph_q == fgrc_pkg::PH_LOAD) && start && (n_q < CW'(MAX_NODES));

	always_ff @(posedge clk) begin
		if (ld_we)
			succ_mem[n_q[AW-1:0]] <= item.successor;
		succ_rd_q <= succ_mem[s_ra];
	end

	always_ff @(posedge clk) begin
		if (d_we)
			deg_mem[d_wa] <= d_wd;
		deg_rd_q <= deg_mem[d_ra];
	end

	always_ff @(posedge clk) begin
		if (a_we)
			ans_mem[a_wa] <= a_wd;
		ans_rd_q <= ans_mem[a_ra];
	end

	always_ff @(posedge clk) begin
		if (q_we)
			queue_mem[q_wa] <= q_wd;
		queue_rd_q <= queue_mem[q_ra];
	end

	// table addresses and write strobes for the current phase and step
	always_comb begin
		s_ra = v_idx;
		d_ra = v_idx;
		a_ra = v_idx;
		q_ra = head_q[AW-1:0];
		d_we = 1'b0;
		d_wa = v_idx;
		d_wd = '0;
		a_we = 1'b0;
		a_wa = v_idx;
		a_wd = '0;
		q_we = 1'b0;
		q_wa = tail_q[AW-1:0];
		q_wd = v_idx;
		case (ph_q)
			fgrc_pkg::PH_CLEAR: begin
				d_we = 1'b1;
				a_we = 1'b1;
			end
			fgrc_pkg::PH_DEG: begin
				d_ra = succ_rd_q;
				d_wa = succ_rd_q;
				d_wd = deg_rd_q + CW'(1);
				d_we = !err_q && (step_q == 2'd2);
			end
			fgrc_pkg::PH_SEED: begin
				q_we = (step_q == 2'd1) && (deg_rd_q == '0);
			end
			fgrc_pkg::PH_PEEL: begin
				s_ra = queue_rd_q;
				d_ra = succ_rd_q;
				d_wa = succ_rd_q;
				d_wd = deg_rd_q - CW'(1);
				d_we = (step_q == 2'd3);
				q_wd = succ_rd_q;
				q_we = (step_q == 2'd3) && (deg_rd_q == CW'(1)) && (tail_q < n_q);
			end
			fgrc_pkg::PH_CWALK: begin
				s_ra = w_q;
			end
			fgrc_pkg::PH_CMARK: begin
				s_ra = w_q;
				a_wa = w_q;
				a_wd = len_q;
				a_we = (step_q == 2'd0);
			end
			fgrc_pkg::PH_TAIL: begin
				q_ra = tail_dec[AW-1:0];
				s_ra = queue_rd_q;
				a_ra = succ_rd_q;
				a_wa = queue_rd_q;
				a_wd = (ans_rd_q == {CW{1'b1}}) ? {CW{1'b1}} : ans_rd_q + CW'(1);
				a_we = (step_q == 2'd3);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= fgrc_pkg::PH_CLEAR;
			n_q <= '0;
			err_q <= 1'b0;
			v_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			w_q <= '0;
			len_q <= '0;
			step_q <= '0;
			strobe <= 1'b0;
			result <= '0;
		end else begin
			strobe <= 1'b0;
			case (ph_q)
				fgrc_pkg::PH_CLEAR: begin
					if (v_q == CW'(MAX_NODES - 1)) begin
						v_q <= '0;
						n_q <= '0;
						err_q <= 1'b0;
						ph_q <= fgrc_pkg::PH_LOAD;
					end else begin
						v_q <= v_q + CW'(1);
					end
				end
				fgrc_pkg::PH_LOAD: begin
					if (start) begin
						if (n_q < CW'(MAX_NODES)) n_q <= n_q + CW'(1);
						else err_q <= 1'b1;
						if (item.last_node) begin
							v_q <= '0;
							step_q <= '0;
							ph_q <= fgrc_pkg::PH_RANGE;
						end
					end
				end
				fgrc_pkg::PH_RANGE: begin
					if (step_q == 2'd0) step_q <= 2'd1;
					else begin
						step_q <= '0;
						if (CW'(succ_rd_q) >= n_q) err_q <= 1'b1;
						if (v_end) begin
							v_q <= '0;
							ph_q <= fgrc_pkg::PH_DEG;
						end else v_q <= v_q + CW'(1);
					end
				end
				fgrc_pkg::PH_DEG: begin
					if (err_q) begin
						v_q <= '0;
						step_q <= '0;
						ph_q <= fgrc_pkg::PH_EMIT;
					end else if (step_q != 2'd2) begin
						step_q <= step_q + 2'd1;
					end else begin
						// read succ, read its counter, write it back incremented
						step_q <= '0;
						if (v_end) begin
							v_q <= '0;
							tail_q <= '0;
							ph_q <= fgrc_pkg::PH_SEED;
						end else v_q <= v_q + CW'(1);
					end
				end
				fgrc_pkg::PH_SEED: begin
					if (step_q == 2'd0) step_q <= 2'd1;
					else begin
						step_q <= '0;
						if (deg_rd_q == '0) tail_q <= tail_q + CW'(1);
						if (v_end) begin
							head_q <= '0;
							ph_q <= fgrc_pkg::PH_PEEL;
						end else v_q <= v_q + CW'(1);
					end
				end
				fgrc_pkg::PH_PEEL: begin
					if (step_q == 2'd0) begin
						if (head_q == tail_q) begin
							v_q <= '0;
							ph_q <= fgrc_pkg::PH_CSCAN;
						end else step_q <= 2'd1;
					end else if (step_q != 2'd3) begin
						step_q <= step_q + 2'd1;
					end else begin
						step_q <= '0;
						head_q <= head_q + CW'(1);
						if (deg_rd_q == CW'(1) && tail_q < n_q)
							tail_q <= tail_q + CW'(1);
					end
				end
				fgrc_pkg::PH_CSCAN: begin
					if (step_q == 2'd0) step_q <= 2'd1;
					else begin
						step_q <= '0;
						if (deg_rd_q != '0 && ans_rd_q == '0) begin
							w_q <= succ_rd_q;
							len_q <= CW'(1);
							ph_q <= fgrc_pkg::PH_CWALK;
						end else if (v_end) begin
							ph_q <= fgrc_pkg::PH_TAIL;
						end else v_q <= v_q + CW'(1);
					end
				end
				fgrc_pkg::PH_CWALK: begin
					if (step_q == 2'd0) begin
						if (w_q != v_idx && len_q < n_q) step_q <= 2'd1;
						else begin
							w_q <= v_idx;
							head_q <= '0;
							ph_q <= fgrc_pkg::PH_CMARK;
						end
					end else begin
						step_q <= '0;
						w_q <= succ_rd_q;
						len_q <= len_q + CW'(1);
					end
				end
				fgrc_pkg::PH_CMARK: begin
					if (step_q == 2'd0) step_q <= 2'd1;
					else begin
						step_q <= '0;
						w_q <= succ_rd_q;
						head_q <= head_q + CW'(1);
						if (head_q + CW'(1) == len_q) begin
							if (v_end) ph_q <= fgrc_pkg::PH_TAIL;
							else begin
								v_q <= v_q + CW'(1);
								ph_q <= fgrc_pkg::PH_CSCAN;
							end
						end
					end
				end
				fgrc_pkg::PH_TAIL: begin
					if (step_q == 2'd0) begin
						if (tail_q == '0) begin
							v_q <= '0;
							ph_q <= fgrc_pkg::PH_EMIT;
						end else step_q <= 2'd1;
					end else if (step_q != 2'd3) begin
						step_q <= step_q + 2'd1;
					end else begin
						step_q <= '0;
						tail_q <= tail_q - CW'(1);
					end
				end
				fgrc_pkg::PH_EMIT: begin
					if (step_q == 2'd0) step_q <= 2'd1;
					else begin
						step_q <= '0;
						strobe <= 1'b1;
						result.visited_count <= err_q ? '0 : ans_rd_q;
						result.bad_graph <= err_q;
						result.end_of_run <= v_end;
						if (v_end) begin
							v_q <= '0;
							ph_q <= fgrc_pkg::PH_CLEAR;
						end else v_q <= v_q + CW'(1);
					end
				end
				default: ph_q <= fgrc_pkg::PH_CLEAR;
			endcase
		end
	end

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy)) else $error("strobe while idle");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.bad_graph) |-> result.visited_count == '0)
		else $error("nonzero count on error");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CW'(MAX_NODES)) else $error("node count overflow");
	a_queue: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q || ph_q != fgrc_pkg::PH_PEEL) else $error("queue underrun");
endmodule

[design/functional_graph_reach_count.sv]
// Top level of the functional-graph reach counter.
// Usage: after reset the block clears its degree and answer tables with
// busy high. Then it takes one node per cycle: pulse start with item.successor
// while busy is low; the node with item.last_node set closes the graph.
// busy then rises and the block checks ranges, counts in-degrees, seeds the
// peel queue, drains it, scans for rings, walks and marks each ring and fills
// the tails; every table read is registered, so each step is a short sequence
// of registered reads and writes. It then emits one result per node, in node
// order, on result marked by strobe, end_of_run on the last. The receiver
// cannot stall. On error (successor out of range, or more than MAX_NODES
// nodes) the block skips straight to emitting after the range check; all
// counts are zero with bad_graph set. After emitting, a clearing pass runs
// before the next graph is accepted.
`timescale 1ns / 1ps
module functional_graph_reach_count #(
	parameter int MAX_NODES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  fgrc_pkg::item_t    item,
	output logic               busy,
	output logic               strobe,
	output fgrc_pkg::result_t  result
);
	fgrc_core #(.MAX_NODES(MAX_NODES)) u_core (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item),
		.busy(busy), .strobe(strobe), .result(result)
	);
endmodule

[test/functional_graph_reach_count_test.sv]
// Testbench for the functional-graph reach counter: directed table plus random graphs.
`timescale 1ns / 1ps
module functional_graph_reach_count_test;
	localparam int NODES = 64;
	localparam int WATCHDOG = 20000;
	localparam int IW = fgrc_pkg::IDX_W;
	localparam int CNW = fgrc_pkg::CNT_W;

	logic              clk;
	logic              arst_n;
	logic              start;
	fgrc_pkg::item_t   item;
	logic              busy;
	logic              strobe;
	fgrc_pkg::result_t result;

	functional_graph_reach_count #(.MAX_NODES(NODES)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item),
		.busy(busy), .strobe(strobe), .result(result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// predictor state for the graph being loaded
	logic [IW-1:0]     succ_mem [NODES];
	int                node_total;
	logic              overflow;
	fgrc_pkg::result_t pending_results [$];
	int                errors;
	int                idle_cycles;

	// stimulus table: successor, last mark, typed-in expected count (-1 = predictor)
	typedef struct {
		logic [IW-1:0] successor;
		logic          last_node;
		int            typed_count;
	} row_t;
	row_t rows [$];

	function automatic void predict_graph();
		int  n;
		logic bad;
		int  indeg [NODES];
		int  queue [NODES];
		int  answer [NODES];
		int  head, tl, w, len, u;
		n = node_total;
		bad = overflow;
		for (int v = 0; v < n; v++) begin
			indeg[v] = 0;
			answer[v] = 0;
			if (succ_mem[v] >= n) bad = 1'b1;
		end
		if (!bad) begin
			for (int v = 0; v < n; v++) indeg[succ_mem[v]]++;
			head = 0;
			tl = 0;
			for (int v = 0; v < n; v++)
				if (indeg[v] == 0) queue[tl++] = v;
			while (head < tl) begin
				w = succ_mem[queue[head++]];
				indeg[w]--;
				if (indeg[w] == 0 && tl < n) queue[tl++] = w;
			end
			for (int v = 0; v < n; v++) begin
				if (indeg[v] != 0 && answer[v] == 0) begin
					w = succ_mem[v];
					len = 1;
					while (w != v && len < n) begin
						w = succ_mem[w];
						len++;
					end
					w = v;
					for (int k = 0; k < len; k++) begin
						answer[w] = len;
						w = succ_mem[w];
					end
				end
			end
			while (tl > 0) begin
				u = queue[--tl];
				answer[u] = answer[succ_mem[u]] + 1;
				if (answer[u] > 127) answer[u] = 127;
			end
		end
		for (int v = 0; v < n; v++) begin
			fgrc_pkg::result_t r;
			r.visited_count = bad ? '0 : answer[v][CNW-1:0];
			r.bad_graph = bad;
			r.end_of_run = (v + 1 == n);
			pending_results.insert(pending_results.size(), r);
		end
		node_total = 0;
		overflow = 1'b0;
	endfunction

	function automatic void model_item(fgrc_pkg::item_t it);
		if (node_total < NODES) succ_mem[node_total++] = it.successor;
		else overflow = 1'b1;
		if (it.last_node) predict_graph();
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			fgrc_pkg::result_t e;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %p", $time, result);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (result.visited_count !== e.visited_count) begin
					$display("%0t: visited_count expected %0d actual %0d", $time,
						e.visited_count, result.visited_count);
					errors++;
				end
				if (result.bad_graph !== e.bad_graph) begin
					$display("%0t: bad_graph expected %0b actual %0b", $time,
						e.bad_graph, result.bad_graph);
					errors++;
				end
				if (result.end_of_run !== e.end_of_run) begin
					$display("%0t: end_of_run expected %0b actual %0b", $time,
						e.end_of_run, result.end_of_run);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction either way
	always @(posedge clk) begin
		if ((start && !busy) || strobe) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// one transaction; start stays high across back-to-back items
	task automatic send_item(fgrc_pkg::item_t it, bit keep_gaps);
		int g;
		g = keep_gaps ? gap_len() : 0;
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		model_item(it);
	endtask

	task automatic add_row(int s, bit l, int c);
		row_t r;
		r.successor = IW'(s);
		r.last_node = l;
		r.typed_count = c;
		rows.insert(rows.size(), r);
	endtask

	// random graph: mostly well-formed, some out of range, rare overflow
	task automatic send_random_graph(bit gaps, ref int sent);
		int              n, kind;
		fgrc_pkg::item_t it;
		kind = $urandom_range(0, 99);
		if (kind < 70) n = $urandom_range(2, 12);
		else if (kind < 95) n = $urandom_range(1, 40);
		else n = $urandom_range(60, 66);
		for (int v = 0; v < n; v++) begin
			if ($urandom_range(0, 19) == 0) it.successor = IW'($urandom_range(0, 63));
			else it.successor = IW'($urandom_range(0, n - 1 > 63 ? 63 : n - 1));
			it.last_node = (v == n - 1);
			send_item(it, gaps);
			sent++;
		end
	endtask

	initial begin
		fgrc_pkg::item_t it;
		int              sent;
		int              typed;
		errors = 0;
		idle_cycles = 0;
		node_total = 0;
		overflow = 1'b0;
		start = 1'b0;
		item = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single self loop: count 1
		add_row(0, 1, 1);
		// two-node ring
		add_row(1, 0, -1);
		add_row(0, 1, 2);
		// out of range successor: zero counts
		add_row(63, 0, 0);
		add_row(0, 1, 0);
		// chain into a self loop, mixed cases
		add_row(1, 0, -1);
		add_row(2, 0, -1);
		add_row(2, 0, -1);
		add_row(0, 0, -1);
		add_row(3, 1, -1);
		// single node pointing past itself
		add_row(1, 1, 0);
		// three-ring with tail
		add_row(1, 0, -1);
		add_row(2, 0, -1);
		add_row(0, 0, -1);
		add_row(0, 1, -1);

		foreach (rows[i]) begin
			it.successor = rows[i].successor;
			it.last_node = rows[i].last_node;
			typed = pending_results.size();
			send_item(it, 1'b0);
			if (rows[i].typed_count >= 0 && pending_results.size() > typed)
				if (pending_results[pending_results.size() - 1].visited_count
					!= rows[i].typed_count) begin
					$display("%0t: table row %0d expected %0d predicted %0d", $time, i,
						rows[i].typed_count,
						pending_results[pending_results.size() - 1].visited_count);
					errors++;
				end
		end

		// full 64-node ring, then overflow by one
		for (int v = 0; v < NODES; v++) begin
			it.successor = IW'((v + 1) % NODES);
			it.last_node = (v == NODES - 1);
			send_item(it, 1'b0);
		end
		for (int v = 0; v <= NODES; v++) begin
			it.successor = 6'd63 - v[5:0];
			it.last_node = (v == NODES);
			send_item(it, 1'b0);
		end

		sent = 0;
		while (sent < 200) send_random_graph($urandom_range(0, 3) != 0, sent);
		start <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end
endmodule
